// File: sv/dq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package dq_pkg;

  localparam int unsigned ModeW   = 3;
  localparam int unsigned ValueW  = 32;
  localparam int unsigned StatusW = 2;

  localparam logic [ModeW-1:0] MODE_PUSH_FRONT = 3'd0;
  localparam logic [ModeW-1:0] MODE_PUSH_BACK  = 3'd1;
  localparam logic [ModeW-1:0] MODE_POP_FRONT  = 3'd2;
  localparam logic [ModeW-1:0] MODE_POP_BACK   = 3'd3;
  localparam logic [ModeW-1:0] MODE_PEEK_FRONT = 3'd4;
  localparam logic [ModeW-1:0] MODE_PEEK_BACK  = 3'd5;

  localparam logic [StatusW-1:0] ST_OK    = 2'd0;
  localparam logic [StatusW-1:0] ST_EMPTY = 2'd1;
  localparam logic [StatusW-1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic push_front;
    logic push_back;
    logic pop_front;
    logic pop_back;
  } dq_ctrl_t;

endpackage

`default_nettype wire

// File: sv/dq_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface dq_req_if import dq_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ModeW-1:0]  mode;
  logic [ValueW-1:0] value;

  modport source (output valid, output mode, output value, input ready);
  modport sink (input valid, input mode, input value, output ready);
endinterface

interface dq_rsp_if import dq_pkg::*; #(
  parameter int unsigned CntW = 5
) ();
  logic               valid;
  logic               ready;
  logic [ValueW-1:0]  result_value;
  logic [StatusW-1:0] status;
  logic [CntW-1:0]    count;

  modport source (output valid, output result_value, output status, output count, input ready);
  modport sink (input valid, input result_value, input status, input count, output ready);
endinterface

`default_nettype wire

// File: sv/dq_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module dq_cell import dq_pkg::*; #(
  parameter int unsigned DataWidth = 32
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire dq_ctrl_t             ctrl_i,
  input  wire logic [DataWidth-1:0] value_i,
  input  wire logic                 left_valid_i,
  input  wire logic [DataWidth-1:0] left_data_i,
  input  wire logic                 right_valid_i,
  input  wire logic [DataWidth-1:0] right_data_i,
  output logic                      valid_o,
  output logic [DataWidth-1:0]      data_o
);

  logic                 valid_d, valid_q;
  logic [DataWidth-1:0] data_d, data_q;

  // A push at the front shifts every word one cell toward the back, a pop at
  // the front shifts them back; the back end only touches its boundary cell.
  always_comb begin
    valid_d = valid_q;
    data_d  = data_q;
    if (ctrl_i.push_front) begin
      valid_d = left_valid_i;
      data_d  = left_data_i;
    end else if (ctrl_i.push_back && !valid_q && left_valid_i) begin
      valid_d = 1'b1;
      data_d  = value_i;
    end else if (ctrl_i.pop_front) begin
      valid_d = right_valid_i;
      data_d  = right_data_i;
    end else if (ctrl_i.pop_back && valid_q && !right_valid_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

`default_nettype wire

// File: sv/double_ended_queue.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel  Dir  Handshake      Word
// req      in   valid/ready    mode, value
// rsp      out  valid/ready    result_value, status, count
//
// Each request updates the cell row and its answer is registered in the output
// register on the next cycle; one request per cycle is sustained while rsp is ready.
// Reset empties the queue by clearing the valid bit of every cell.
// A new request is taken whenever the output register is empty or is being
// read in the same cycle, so a stalled response blocks only further requests.

module double_ended_queue import dq_pkg::*; #(
  parameter int unsigned Depth     = 16,
  parameter int unsigned DataWidth = 32
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  dq_req_if.sink    req,
  dq_rsp_if.source  rsp
);

  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Depth-1:0]                 cell_valid;
  logic [Depth-1:0][DataWidth-1:0]  cell_data;
  logic [Depth-1:0]                 cell_last;
  logic [DataWidth-1:0]             word;
  logic [DataWidth-1:0]             back_data;
  logic                             accept;
  logic                             empty, full;
  dq_ctrl_t                         ctrl;
  logic [DataWidth-1:0]             answer;
  logic [StatusW-1:0]               status;
  logic [CntW-1:0]                  count_d, count_q;
  logic                             out_valid_q;
  logic [ValueW-1:0]                out_value_q;
  logic [StatusW-1:0]               out_status_q;
  logic [CntW-1:0]                  out_count_q;

  assign word   = DataWidth'(req.value);
  assign empty  = !cell_valid[0];
  assign full   = cell_valid[Depth-1];
  assign accept = req.valid && req.ready;

  assign req.ready = !out_valid_q || rsp.ready;

  for (genvar i = 0; i < Depth; i++) begin : g_cell
    logic                 left_valid, right_valid;
    logic [DataWidth-1:0] left_data, right_data;

    if (i == 0) begin : g_head
      assign left_valid = 1'b1;
      assign left_data  = word;
    end else begin : g_mid_l
      assign left_valid = cell_valid[i-1];
      assign left_data  = cell_data[i-1];
    end

    if (i == Depth - 1) begin : g_tail
      assign right_valid  = 1'b0;
      assign right_data   = '0;
      assign cell_last[i] = cell_valid[i];
    end else begin : g_mid_r
      assign right_valid  = cell_valid[i+1];
      assign right_data   = cell_data[i+1];
      assign cell_last[i] = cell_valid[i] && !cell_valid[i+1];
    end

    dq_cell #(
      .DataWidth(DataWidth)
    ) u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .ctrl_i        (ctrl),
      .value_i       (word),
      .left_valid_i  (left_valid),
      .left_data_i   (left_data),
      .right_valid_i (right_valid),
      .right_data_i  (right_data),
      .valid_o       (cell_valid[i]),
      .data_o        (cell_data[i])
    );
  end

  // At most one cell is flagged as the back, so an AND-OR picks its word.
  always_comb begin
    back_data = '0;
    for (int i = 0; i < Depth; i++) begin
      back_data = back_data | (cell_data[i] & {DataWidth{cell_last[i]}});
    end
  end

  always_comb begin
    ctrl    = '0;
    answer  = '0;
    status  = ST_OK;
    count_d = count_q;
    case (req.mode)
      MODE_PUSH_FRONT, MODE_PUSH_BACK: begin
        if (full) begin
          status = ST_FULL;
        end else begin
          ctrl.push_front = accept && (req.mode == MODE_PUSH_FRONT);
          ctrl.push_back  = accept && (req.mode == MODE_PUSH_BACK);
          answer          = word;
          count_d         = count_q + CntW'(1);
        end
      end
      MODE_POP_FRONT, MODE_PEEK_FRONT: begin
        if (empty) begin
          status = ST_EMPTY;
        end else begin
          ctrl.pop_front = accept && (req.mode == MODE_POP_FRONT);
          answer         = cell_data[0];
          if (req.mode == MODE_POP_FRONT) begin
            count_d = count_q - CntW'(1);
          end
        end
      end
      MODE_POP_BACK, MODE_PEEK_BACK: begin
        if (empty) begin
          status = ST_EMPTY;
        end else begin
          ctrl.pop_back = accept && (req.mode == MODE_POP_BACK);
          answer        = back_data;
          if (req.mode == MODE_POP_BACK) begin
            count_d = count_q - CntW'(1);
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (rsp.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_value_q  <= ValueW'(answer);
      out_status_q <= status;
      out_count_q  <= count_d;
    end
  end

  assign rsp.valid        = out_valid_q;
  assign rsp.result_value = out_value_q;
  assign rsp.status       = out_status_q;
  assign rsp.count        = out_count_q;

  a_empty_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0) == !cell_valid[0])
    else $error("Fill count and front cell disagree on emptiness.");

  a_full_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == CntW'(Depth)) == cell_valid[Depth-1])
    else $error("Fill count and back cell disagree on fullness.");

  a_packed_cells : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(cell_valid ^ (cell_valid >> 1)))
    else $error("Occupied cells are not packed toward the front.");

  a_full_refused : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && full && (req.mode == MODE_PUSH_FRONT || req.mode == MODE_PUSH_BACK)
    |=> rsp.valid && rsp.status == ST_FULL && $stable(cell_valid))
    else $error("Push into a full queue was not refused.");

endmodule

`default_nettype wire

// File: tb/tb.sv
`timescale 1ns / 1ps

module tb;
  import dq_pkg::*;

  localparam int unsigned Depth     = 16;
  localparam int unsigned CntW      = 5;
  localparam logic [ModeW-1:0] MODE_SPARE_6 = 3'd6;
  localparam logic [ModeW-1:0] MODE_SPARE_7 = 3'd7;

  typedef struct packed {
    logic [ValueW-1:0]  value;
    logic [StatusW-1:0] status;
    logic [CntW-1:0]    count;
  } dq_answer_t;

  logic clk_i;
  logic rst_ni;

  dq_req_if               req_bus ();
  dq_rsp_if #(.CntW(CntW)) rsp_bus ();

  double_ended_queue #(
    .Depth    (Depth),
    .DataWidth(ValueW)
  ) u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req   (req_bus.sink),
    .rsp   (rsp_bus.source)
  );

  logic [ValueW-1:0] deq_words [Depth];
  logic [3:0]        deq_head;
  logic [CntW-1:0]   deq_fill;
  dq_answer_t        answer_q [$];

  int fail_count;
  int words_sent;
  int answers_checked;
  int full_refusals;
  int empty_refusals;
  int send_idle_pct;
  int recv_stall_pct;
  int hold_len;
  int hold_req_cnt;
  int hold_seen;
  int hold_left;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("TEST FAILED");
    $finish;
  end

  function automatic dq_answer_t predict_answer(logic [ModeW-1:0] mode,
                                                logic [ValueW-1:0] value);
    dq_answer_t ans;
    logic [3:0] pos;
    ans.value  = '0;
    ans.status = ST_OK;
    case (mode)
      MODE_PUSH_FRONT, MODE_PUSH_BACK: begin
        if (deq_fill >= Depth) begin
          ans.status = ST_FULL;
        end else begin
          if (mode == MODE_PUSH_FRONT) begin
            deq_head = deq_head - 4'd1;
            pos = deq_head;
          end else begin
            pos = deq_head + deq_fill[3:0];
          end
          deq_words[pos] = value;
          deq_fill = deq_fill + 1'b1;
          ans.value = value;
        end
      end
      MODE_POP_FRONT, MODE_POP_BACK, MODE_PEEK_FRONT, MODE_PEEK_BACK: begin
        if (deq_fill == 0) begin
          ans.status = ST_EMPTY;
        end else begin
          if (mode == MODE_POP_FRONT || mode == MODE_PEEK_FRONT) begin
            pos = deq_head;
          end else begin
            pos = deq_head + deq_fill[3:0] - 4'd1;
          end
          ans.value = deq_words[pos];
          if (mode == MODE_POP_FRONT) begin
            deq_head = deq_head + 4'd1;
            deq_fill = deq_fill - 1'b1;
          end else if (mode == MODE_POP_BACK) begin
            deq_fill = deq_fill - 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
    ans.count = deq_fill;
    return ans;
  endfunction

  always @(posedge clk_i) begin
    dq_answer_t want;
    if (rst_ni) begin
      if (rsp_bus.valid && rsp_bus.ready) begin
        if (answer_q.size() == 0) begin
          $display("%0t: answer with none expected: value %h status %0d count %0d",
                   $time, rsp_bus.result_value, rsp_bus.status, rsp_bus.count);
          fail_count++;
        end else begin
          want = answer_q.pop_front();
          answers_checked++;
          if (want.status == ST_FULL) full_refusals++;
          if (want.status == ST_EMPTY) empty_refusals++;
          if (rsp_bus.result_value !== want.value) begin
            $display("%0t: result_value expected %h actual %h",
                     $time, want.value, rsp_bus.result_value);
            fail_count++;
          end
          if (rsp_bus.status !== want.status) begin
            $display("%0t: status expected %0d actual %0d",
                     $time, want.status, rsp_bus.status);
            fail_count++;
          end
          if (rsp_bus.count !== want.count) begin
            $display("%0t: count expected %0d actual %0d",
                     $time, want.count, rsp_bus.count);
            fail_count++;
          end
        end
      end
      if (req_bus.valid && req_bus.ready) begin
        answer_q.push_back(predict_answer(req_bus.mode, req_bus.value));
      end
    end
  end

  // The receiver stalls at random, or holds off completely for a requested stretch.
  always @(posedge clk_i) begin
    if (hold_req_cnt != hold_seen) begin
      hold_seen = hold_req_cnt;
      hold_left = hold_len;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      rsp_bus.ready <= 1'b0;
    end else begin
      rsp_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic send_word(input logic [ModeW-1:0] mode, input logic [ValueW-1:0] value);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      req_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_bus.valid <= 1'b1;
    req_bus.mode  <= mode;
    req_bus.value <= value;
    @(posedge clk_i);
    while (!req_bus.ready) @(posedge clk_i);
    words_sent++;
  endtask

  task automatic wait_drained();
    req_bus.valid <= 1'b0;
    @(posedge clk_i);
    while (answer_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  function automatic logic [ValueW-1:0] pick_value();
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      2: return 32'hAAAA_AAAA;
      3: return 32'h5555_5555;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [ModeW-1:0] pick_mode(int push_pct);
    int r;
    r = $urandom_range(99);
    if (r < 3) return ($urandom_range(1) != 0) ? MODE_SPARE_7 : MODE_SPARE_6;
    if ($urandom_range(99) < push_pct) begin
      return ($urandom_range(1) != 0) ? MODE_PUSH_BACK : MODE_PUSH_FRONT;
    end
    case ($urandom_range(4))
      0: return MODE_PEEK_FRONT;
      1: return MODE_PEEK_BACK;
      2, 3: return MODE_POP_FRONT;
      default: return MODE_POP_BACK;
    endcase
  endfunction

  task automatic test_empty_queue();
    send_word(MODE_PEEK_FRONT, '1);
    send_word(MODE_PEEK_BACK, '0);
    send_word(MODE_POP_FRONT, 32'h1234_5678);
    send_word(MODE_POP_BACK, '1);
  endtask

  task automatic test_single_word();
    send_word(MODE_PUSH_BACK, '0);
    send_word(MODE_PEEK_BACK, '1);
    send_word(MODE_POP_FRONT, '0);
    send_word(MODE_PUSH_FRONT, '1);
    send_word(MODE_PEEK_FRONT, '0);
    send_word(MODE_POP_BACK, '0);
  endtask

  task automatic test_unused_modes();
    send_word(MODE_SPARE_6, '1);
    send_word(MODE_SPARE_7, 32'hDEAD_BEEF);
  endtask

  task automatic test_full_queue();
    for (int i = 0; i < Depth; i++) begin
      send_word((i % 2 == 0) ? MODE_PUSH_BACK : MODE_PUSH_FRONT, pick_value());
    end
    send_word(MODE_PUSH_FRONT, '1);
    send_word(MODE_PUSH_BACK, '1);
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_stall_pct <= 0;
    hold_len = 300;
    hold_req_cnt <= hold_req_cnt + 1;
    for (int i = 0; i < 60; i++) send_word(pick_mode(60), pick_value());
  endtask

  task automatic test_random(input int count, input int push_pct);
    for (int i = 0; i < count; i++) send_word(pick_mode(push_pct), pick_value());
  endtask

  initial begin
    rst_ni = 1'b0;
    req_bus.valid = 1'b0;
    req_bus.mode  = '0;
    req_bus.value = '0;
    rsp_bus.ready = 1'b0;
    deq_head = '0;
    deq_fill = '0;
    fail_count = 0;
    words_sent = 0;
    answers_checked = 0;
    full_refusals = 0;
    empty_refusals = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_len = 0;
    hold_req_cnt = 0;
    hold_seen = 0;
    hold_left = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_queue();
    test_single_word();
    test_unused_modes();
    test_full_queue();
    wait_drained();
    test_backpressure();
    wait_drained();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct <= 0;  end
        1: begin send_idle_pct = 80; recv_stall_pct <= 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct <= 80; end
        default: begin send_idle_pct = 9; recv_stall_pct <= 9; end
      endcase
      test_random(125, 70);
      test_random(125, 30);
      test_random(125, 50);
      wait_drained();
    end

    repeat (20) @(posedge clk_i);
    if (answer_q.size() != 0) begin
      $display("%0t: %0d answers expected but never seen", $time, answer_q.size());
      fail_count++;
    end
    $display("Sent %0d words and checked %0d answers under four idling patterns.",
             words_sent, answers_checked);
    $display("Saw %0d full refusals and %0d empty refusals; %0d mismatches.",
             full_refusals, empty_refusals, fail_count);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
